### rtl/core/pyth_pkg.sv
// ----------------------------------------------------------------------------
// pyth_pkg
// Shared types and constants for the Pythagorean triple classifier.
// ----------------------------------------------------------------------------
package pyth_pkg;

    localparam int FIELD_WIDTH    = 32;
    localparam int SIDE_WIDTH_DEF = 32;
    localparam int NUM_SIDES      = 3;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] side_a;
        logic signed [FIELD_WIDTH-1:0] side_b;
        logic signed [FIELD_WIDTH-1:0] side_c;
    } t_in;

    typedef struct packed {
        logic is_right_triple;
        logic is_primitive;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQR,
        S_CMP,
        S_GO,
        S_GCD_AB,
        S_GCD_C,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        G_IDLE,
        G_STRIP,
        G_NORM,
        G_LOOP
    } t_gstate;

endpackage

### rtl/core/pyth_gcd.sv
// ----------------------------------------------------------------------------
// pyth_gcd
// Binary (Stein) gcd unit: one halve, swap or subtract step per cycle.
// ----------------------------------------------------------------------------
module pyth_gcd import pyth_pkg::*; #(
    parameter int W = SIDE_WIDTH_DEF - 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_x,
    input  logic [W-1:0] i_y,
    output logic         o_done,
    output logic [W-1:0] o_gcd
);

    localparam int SHW = $clog2(W) + 1;

    t_gstate        r_state, n_state;
    logic [W-1:0]   r_x, n_x;
    logic [W-1:0]   r_y, n_y;
    logic [SHW-1:0] r_shift, n_shift;
    logic [W-1:0]   r_res, n_res;
    logic           r_done, n_done;

    logic           x_gt_y;
    logic [W-1:0]   diff;

    assign x_gt_y = r_x > r_y;
    assign diff   = x_gt_y ? (r_x - r_y) : (r_y - r_x);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            G_IDLE: begin
                if (i_start) begin
                    n_state = G_STRIP;
                end
            end
            G_STRIP: begin
                if (r_x == '0 || r_y == '0) begin
                    n_state = G_IDLE;
                end else if (r_x[0] || r_y[0]) begin
                    n_state = G_NORM;
                end
            end
            G_NORM: begin
                if (r_x[0]) begin
                    n_state = G_LOOP;
                end
            end
            G_LOOP: begin
                if (r_y == '0) begin
                    n_state = G_IDLE;
                end
            end
            default: n_state = G_IDLE;
        endcase
    end

    always_comb begin
        n_x     = r_x;
        n_y     = r_y;
        n_shift = r_shift;
        n_res   = r_res;
        n_done  = 1'b0;
        unique case (r_state)
            G_IDLE: begin
                if (i_start) begin
                    n_x     = i_x;
                    n_y     = i_y;
                    n_shift = '0;
                end
            end
            G_STRIP: begin
                if (r_x == '0) begin
                    n_res  = r_y;
                    n_done = 1'b1;
                end else if (r_y == '0) begin
                    n_res  = r_x;
                    n_done = 1'b1;
                end else if (!(r_x[0] || r_y[0])) begin
                    n_x     = r_x >> 1;
                    n_y     = r_y >> 1;
                    n_shift = r_shift + 1'b1;
                end
            end
            G_NORM: begin
                if (!r_x[0]) begin
                    n_x = r_x >> 1;
                end
            end
            G_LOOP: begin
                if (r_y == '0) begin
                    n_res  = r_x << r_shift;
                    n_done = 1'b1;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else begin
                    if (x_gt_y) begin
                        n_x = r_y;
                    end
                    n_y = diff >> 1;
                end
            end
            default: n_done = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_x     <= n_x;
        r_y     <= n_y;
        r_shift <= n_shift;
        r_res   <= n_res;
    end

    assign o_done = r_done;
    assign o_gcd  = r_res;

endmodule

### rtl/core/pythagorean_triple_classifier.sv
// ----------------------------------------------------------------------------
// pythagorean_triple_classifier
// Flags right triples among three signed sides and whether they are coprime.
// ----------------------------------------------------------------------------
// One request is taken at a time. The three squares come from one shared
// multiplier, the three Pythagoras sums from one shared adder and
// comparator, and for a right triple a single binary gcd unit runs twice,
// one step per cycle; a request that is not a right triple skips the gcd.
// The result sits in an output register, so the next request is taken as
// soon as the last one finishes even while its result still waits.
module pythagorean_triple_classifier import pyth_pkg::*; #(
    parameter int SIDE_WIDTH = SIDE_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    localparam int M  = SIDE_WIDTH - 1;
    localparam int SQ = 2 * M;

    t_state        r_state, n_state;
    logic [1:0]    r_cnt, n_cnt;
    logic [M-1:0]  r_m0, r_m1, r_m2;
    logic [SQ-1:0] r_s0, r_s1, r_s2;
    logic          r_pos;
    logic          r_right, n_right;
    logic          r_prim;
    logic          r_out_valid;
    t_out          r_out;

    logic          in_acc;
    logic          last;
    logic          eq;
    logic          pos_a, pos_b, pos_c;
    logic          rotate;
    logic          gcd_start;
    logic [M-1:0]  gcd_x, gcd_y;
    logic          gcd_done;
    logic [M-1:0]  gcd_res;
    logic          out_load;

    assign in_acc = i_in_valid && !o_in_stall;
    assign last   = (r_cnt == 2'(NUM_SIDES - 1));
    assign eq     = ({1'b0, r_s0} + {1'b0, r_s1}) == {1'b0, r_s2};

    assign pos_a = !i_in.side_a[SIDE_WIDTH-1] && (i_in.side_a[M-1:0] != '0);
    assign pos_b = !i_in.side_b[SIDE_WIDTH-1] && (i_in.side_b[M-1:0] != '0);
    assign pos_c = !i_in.side_c[SIDE_WIDTH-1] && (i_in.side_c[M-1:0] != '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_SQR;
                end
            end
            S_SQR: begin
                if (last) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (last) begin
                    n_state = (r_pos && (r_right || eq)) ? S_GO : S_FIN;
                end
            end
            S_GO:     n_state = S_GCD_AB;
            S_GCD_AB: begin
                if (gcd_done) begin
                    n_state = S_GCD_C;
                end
            end
            S_GCD_C: begin
                if (gcd_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cnt     = '0;
        n_right   = r_right;
        rotate    = 1'b0;
        gcd_start = 1'b0;
        gcd_x     = r_m0;
        gcd_y     = r_m1;
        out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_right = 1'b0;
            end
            S_SQR: begin
                rotate = 1'b1;
                n_cnt  = last ? '0 : r_cnt + 1'b1;
            end
            S_CMP: begin
                rotate  = 1'b1;
                n_cnt   = last ? '0 : r_cnt + 1'b1;
                n_right = r_right || eq;
                if (last) begin
                    n_right = r_pos && (r_right || eq);
                end
            end
            S_GO: begin
                gcd_start = 1'b1;
            end
            S_GCD_AB: begin
                gcd_start = gcd_done;
                gcd_x     = gcd_res;
                gcd_y     = r_m2;
            end
            S_GCD_C: begin
                gcd_x = gcd_res;
                gcd_y = r_m2;
            end
            S_FIN: begin
                out_load = !r_out_valid || !i_out_stall;
            end
            default: n_cnt = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_right     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_right <= n_right;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_acc) begin
            r_m0  <= i_in.side_a[M-1:0];
            r_m1  <= i_in.side_b[M-1:0];
            r_m2  <= i_in.side_c[M-1:0];
            r_pos <= pos_a && pos_b && pos_c;
        end else if (rotate) begin
            r_m0 <= r_m1;
            r_m1 <= r_m2;
            r_m2 <= r_m0;
        end
        if (r_state == S_SQR) begin
            r_s0 <= r_s1;
            r_s1 <= r_s2;
            r_s2 <= r_m0 * r_m0;
        end else if (r_state == S_CMP) begin
            r_s0 <= r_s1;
            r_s1 <= r_s2;
            r_s2 <= r_s0;
        end
        if (r_state == S_IDLE) begin
            r_prim <= 1'b0;
        end else if (r_state == S_GCD_C && gcd_done) begin
            r_prim <= (gcd_res == M'(1));
        end
        if (out_load) begin
            r_out.is_right_triple <= r_right;
            r_out.is_primitive    <= r_prim;
        end
    end

    pyth_gcd #(
        .W(M)
    ) u_gcd (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(gcd_start),
        .i_x    (gcd_x),
        .i_y    (gcd_y),
        .o_done (gcd_done),
        .o_gcd  (gcd_res)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### rtl/core/pyth_chk.sv
// ----------------------------------------------------------------------------
// pyth_chk
// Port-level checks for the Pythagorean triple classifier.
// ----------------------------------------------------------------------------
module pyth_chk import pyth_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input t_in  i_in,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out
);

    logic unused_in;
    assign unused_in = ^i_in;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out))
        else $error("stalled result changed");

    a_prim_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.is_right_triple || !o_out.is_primitive))
        else $error("primitive flag without right triple");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while not busy afterward");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a request in progress");

endmodule

bind pythagorean_triple_classifier pyth_chk u_pyth_chk (.*);

### tb/pythagorean_triple_classifier_tb.sv
// ----------------------------------------------------------------------------
// pythagorean_triple_classifier_tb
// Self-checking bench: right-triple and primitive flags versus an in-bench
// predictor, with sender bursts, receiver stalls and a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pythagorean_triple_classifier_tb;
    import pyth_pkg::*;

    localparam int  SW           = SIDE_WIDTH_DEF;
    localparam int  LIMIT_CYCLES = 1_500_000;
    localparam int  DRAIN_CYCLES = 300;
    localparam int  HOLD_CYCLES  = 800;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out;

    t_out expected_flags[$];
    int   mismatch_count = 0;
    int   requests_sent  = 0;
    int   right_seen     = 0;
    int   primitive_seen = 0;
    int   cycle_count    = 0;
    int   burst_left     = 0;
    int   stall_pct      = 0;
    int   stall_run      = 0;
    bit   stall_now      = 1'b0;
    int   hold_request   = 0;

    pythagorean_triple_classifier #(
        .SIDE_WIDTH(SW)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [63:0] common_divisor(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic t_out classify_sides(t_in req);
        logic [FIELD_WIDTH-1:0] raw [3];
        logic [63:0]            len [3];
        logic [63:0]            sq  [3];
        logic                   all_pos;
        t_out                   res;
        raw[0]  = req.side_a;
        raw[1]  = req.side_b;
        raw[2]  = req.side_c;
        all_pos = 1'b1;
        res     = '0;
        for (int i = 0; i < 3; i++) begin
            len[i] = {32'b0, raw[i]} & ((64'd1 << SW) - 64'd1);
            sq[i]  = len[i] * len[i];
            if (len[i][SW-1] || len[i] == 0) begin
                all_pos = 1'b0;
            end
        end
        if (all_pos && (sq[0] + sq[1] == sq[2] || sq[0] + sq[2] == sq[1]
                        || sq[2] + sq[1] == sq[0])) begin
            res.is_right_triple = 1'b1;
            res.is_primitive =
                (common_divisor(common_divisor(len[0], len[1]), len[2]) == 64'd1);
        end
        return res;
    endfunction

    // Euclid-formula triple, random scale and order; optionally spoiled.
    function automatic t_in make_triple(bit spoil);
        longint unsigned m, n, h, k, kmax;
        logic [31:0]     s [3];
        logic [31:0]     t;
        int              j;
        int              r;
        m = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 32767) : $urandom_range(2, 60);
        n = $urandom_range(1, int'(m) - 1);
        h = m * m + n * n;
        kmax = 64'd2147483647 / h;
        k = ($urandom_range(0, 1) == 1) ? 1 : $urandom_range(1, int'(kmax));
        s[0] = 32'(k * (m * m - n * n));
        s[1] = 32'(k * 2 * m * n);
        s[2] = 32'(k * h);
        for (j = 2; j > 0; j--) begin
            r    = $urandom_range(0, j);
            t    = s[j];
            s[j] = s[r];
            s[r] = t;
        end
        if (spoil) begin
            j = $urandom_range(0, 2);
            case ($urandom_range(0, 3))
                0: s[j] = s[j] + 1;
                1: s[j] = s[j] - 1;
                2: s[j] = -s[j];
                default: s[j] = '0;
            endcase
        end
        return '{side_a: s[0], side_b: s[1], side_c: s[2]};
    endfunction

    task automatic send_request(t_in req);
        t_out exp_res;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in       <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        exp_res = classify_sides(req);
        expected_flags.push_back(exp_res);
        requests_sent++;
        right_seen     += exp_res.is_right_triple;
        primitive_seen += exp_res.is_primitive;
    endtask

    task automatic send_sides(int a, int b, int c);
        send_request('{side_a: a, side_b: b, side_c: c});
    endtask

    task automatic sender_rest(int cycles);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            sender_rest($urandom_range(1, 20));
            burst_left = $urandom_range(0, 15);
        end
    endtask

    task automatic wait_drained();
        sender_rest(1);
        while (expected_flags.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_sign_and_range_edges();
        stall_pct = 0;
        send_sides(0, 0, 0);
        send_sides(0, 5, 5);
        send_sides(-3, 4, 5);
        send_sides(3, -4, 5);
        send_sides(3, 4, -5);
        send_sides(-1, -1, -1);
        send_sides(1, 1, 1);
        send_sides(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_sides(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_sides(32'h8000_0000, 4, 5);
        send_sides(1, 32'h7fff_ffff, 32'h7fff_ffff);
        send_sides(3, 4, 6);
        wait_drained();
    endtask

    task automatic test_known_triples();
        stall_pct = 0;
        send_sides(3, 4, 5);
        send_sides(5, 3, 4);
        send_sides(3, 5, 4);
        send_sides(5, 12, 13);
        send_sides(8, 15, 17);
        send_sides(20, 21, 29);
        send_sides(6, 8, 10);
        send_sides(9, 12, 15);
        send_sides(32'd1073741823, 32'd65536, 32'd1073741825);
        send_sides(32'd1200000000, 32'd1600000000, 32'd2000000000);
        send_sides(32'd2000000000, 32'd1600000000, 32'd1200000000);
        wait_drained();
    endtask

    task automatic test_random_mix(int count, int receiver_pct);
        t_in req;
        int  pick;
        stall_pct  = receiver_pct;
        burst_left = $urandom_range(0, 15);
        repeat (count) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                req = make_triple($urandom_range(0, 4) == 0);
            end else if (pick < 7) begin
                req.side_a = ($urandom_range(0, 7) == 0) ? -$urandom_range(0, 40)
                                                         : $urandom_range(0, 40);
                req.side_b = ($urandom_range(0, 7) == 0) ? -$urandom_range(0, 40)
                                                         : $urandom_range(0, 40);
                req.side_c = ($urandom_range(0, 7) == 0) ? -$urandom_range(0, 40)
                                                         : $urandom_range(0, 40);
            end else begin
                req = {$urandom, $urandom, $urandom};
            end
            send_request(req);
            pace_sender();
        end
        wait_drained();
    endtask

    // Receiver holds off while requests keep coming, so the input must stall.
    task automatic test_output_holdoff();
        stall_pct    = 0;
        hold_request = HOLD_CYCLES;
        repeat (60) send_request(make_triple($urandom_range(0, 3) == 0));
        wait_drained();
    endtask

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_request) @(negedge i_clk);
                hold_request = 0;
            end else begin
                if (stall_run == 0) begin
                    stall_now = ($urandom_range(0, 99) < stall_pct);
                    stall_run = $urandom_range(1, 8);
                end
                stall_run--;
                i_out_stall <= stall_now;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_flags.size() == 0) begin
                $display("%0t: unexpected result right=%0b primitive=%0b",
                         $time, o_out.is_right_triple, o_out.is_primitive);
                mismatch_count++;
            end else begin
                exp_res = expected_flags.pop_front();
                if (o_out.is_right_triple !== exp_res.is_right_triple) begin
                    $display("%0t: is_right_triple expected %0b got %0b",
                             $time, exp_res.is_right_triple, o_out.is_right_triple);
                    mismatch_count++;
                end
                if (o_out.is_primitive !== exp_res.is_primitive) begin
                    $display("%0t: is_primitive expected %0b got %0b",
                             $time, exp_res.is_primitive, o_out.is_primitive);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d results still pending", $time, expected_flags.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_sign_and_range_edges();
        test_known_triples();
        test_random_mix(400, 0);
        test_random_mix(400, 25);
        test_output_holdoff();
        test_random_mix(400, 60);
        test_random_mix(400, 90);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Ran %0d requests: %0d right triples, %0d of them primitive,",
                 requests_sent, right_seen, primitive_seen);
        $display("with sender bursts, receiver stall patterns and a long output hold-off.");
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### pythagorean_triple_classifier.f
rtl/core/pyth_pkg.sv
rtl/core/pyth_gcd.sv
rtl/core/pythagorean_triple_classifier.sv
rtl/core/pyth_chk.sv
tb/pythagorean_triple_classifier_tb.sv
